// File: hdl/prqs_pkg.sv
// shared widths, command and status codes, register map of the ready-queue scheduler
package prqs_pkg;

  localparam int CMD_W      = 2;
  localparam int LEVEL_W    = 6;
  localparam int CREATOR_W  = 8;
  localparam int RID_W      = 7;
  localparam int STATUS_W   = 3;
  localparam int OUT_ID_W   = 7;
  localparam int OUT_LVL_W  = 4;
  localparam int STACK_W    = 32;
  localparam int BYTES_W    = 25;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CMD_W-1:0] CMD_CREATE   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SCHEDULE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REQUEUE  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_LEVEL  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NO_DESC    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NONE_READY = 3'd3;
  localparam logic [STATUS_W-1:0] ST_UNKNOWN    = 3'd4;

  localparam logic REG_STACK_TOP   = 1'b0;
  localparam logic REG_STACK_BYTES = 1'b1;

  localparam logic [STACK_W-1:0] STACK_TOP_RESET   = 32'd0;
  localparam logic [BYTES_W-1:0] STACK_BYTES_RESET = 25'd4096;

endpackage

// File: hdl/priority_ready_queue_scheduler.sv
// top level: command sequencer over the task memory and the per-level queue memory
//
// Task scheduler with one FIFO ready queue per priority level (0 most urgent).
// Commands enter on start/in_* while busy is low: create, schedule, requeue.
// Each command gives exactly one word on out_*, marked by out_strobe for one
// cycle; the receiver always takes it.
// Steps from the accepting edge to the strobe cycle:
//   create            queue read, then link/tail write
//   schedule          queue read, then task read, then head update
//   requeue           task read, then queue read, then link/tail write
//   rejected commands answered straight from the idle state
// The next command can be accepted at the edge that ends the strobe cycle; the
// memories have a registered read and are accessed one after another.
// Configuration goes through the apb port (stack region top at 0, stack bytes
// per task at 4) and must be written only while the block is idle; the block
// itself does not enforce this.
// Reset empties every queue and restarts descriptor allocation at id 0; the
// memories are not cleared, and read data are only used once written.
module priority_ready_queue_scheduler #(
  parameter int TASK_COUNT  = 128,
  parameter int LEVEL_COUNT = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [prqs_pkg::CMD_W-1:0]            in_cmd,
  input  logic signed [prqs_pkg::LEVEL_W-1:0]   in_level,
  input  logic signed [prqs_pkg::CREATOR_W-1:0] in_creator_id,
  input  logic [prqs_pkg::RID_W-1:0]            in_ready_id,
  output logic                                  out_strobe,
  output logic [prqs_pkg::STATUS_W-1:0]         out_status,
  output logic [prqs_pkg::OUT_ID_W-1:0]         out_chosen_id,
  output logic [prqs_pkg::OUT_LVL_W-1:0]        out_chosen_level,
  output logic signed [prqs_pkg::CREATOR_W-1:0] out_chosen_creator,
  output logic [prqs_pkg::STACK_W-1:0]          out_stack_top,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [prqs_pkg::CFG_ADDR_W-1:0]       paddr,
  input  logic [prqs_pkg::CFG_DATA_W-1:0]       pwdata,
  output logic [prqs_pkg::CFG_DATA_W-1:0]       prdata,
  output logic                                  pready
);

  localparam int ID_W  = $clog2(TASK_COUNT);
  localparam int CNT_W = $clog2(TASK_COUNT + 1);
  localparam int LVL_W = $clog2(LEVEL_COUNT);
  localparam int CR_W  = prqs_pkg::CREATOR_W;
  localparam int TH_W  = LVL_W + CR_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SC_TASK,
    S_SC_POP,
    S_RQ_QUEUE,
    S_APPEND
  } state_t;

  state_t state_r;

  logic [prqs_pkg::STACK_W-1:0] cfg_top;
  logic [prqs_pkg::BYTES_W-1:0] cfg_bytes;

  logic [CNT_W-1:0]             next_free_r;
  logic [LEVEL_COUNT-1:0]       nonempty_r;
  logic [ID_W-1:0]              id_r;
  logic [LVL_W-1:0]             lvl_r;
  logic [CR_W-1:0]              creator_r;
  logic [prqs_pkg::STACK_W-1:0] prod_r;
  logic                         create_r;

  logic                          out_strobe_r;
  logic [prqs_pkg::STATUS_W-1:0] out_status_r;
  logic [prqs_pkg::OUT_ID_W-1:0] out_id_r;
  logic [prqs_pkg::OUT_LVL_W-1:0] out_lvl_r;
  logic [CR_W-1:0]               out_creator_r;
  logic [prqs_pkg::STACK_W-1:0]  out_stack_r;

  // task memory: hi = {level, creator}, lo = next link
  logic              t_rd_en;
  logic [ID_W-1:0]   t_rd_addr;
  logic [TH_W-1:0]   t_rd_hi;
  logic [ID_W-1:0]   t_rd_lo;
  logic              t_we_hi;
  logic              t_we_lo;
  logic [ID_W-1:0]   t_wr_addr;
  logic [TH_W-1:0]   t_wr_hi;
  logic [ID_W-1:0]   t_wr_lo;

  // queue memory: hi = head, lo = tail
  logic              q_rd_en;
  logic [LVL_W-1:0]  q_rd_addr;
  logic [ID_W-1:0]   q_rd_hi;
  logic [ID_W-1:0]   q_rd_lo;
  logic              q_we_hi;
  logic              q_we_lo;
  logic [LVL_W-1:0]  q_wr_addr;
  logic [ID_W-1:0]   q_wr_hi;
  logic [ID_W-1:0]   q_wr_lo;

  logic                         accept;
  logic                         lvl_ok;
  logic                         desc_ok;
  logic                         rq_ok;
  logic                         any_ready;
  logic [LVL_W-1:0]             in_lvl_idx;
  logic [LVL_W-1:0]             sel_lvl;
  logic [ID_W-1:0]              new_id;
  logic [ID_W-1:0]              rq_id;
  logic [prqs_pkg::STACK_W-1:0] prod_full;
  logic [LVL_W-1:0]             t_lvl;
  logic [CR_W-1:0]              t_creator;

  prqs_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .stack_top   (cfg_top),
    .stack_bytes (cfg_bytes)
  );

  prqs_ram #(
    .DEPTH (TASK_COUNT),
    .HI_W  (TH_W),
    .LO_W  (ID_W)
  ) u_task_mem (
    .clk     (clk),
    .rd_en   (t_rd_en),
    .rd_addr (t_rd_addr),
    .rd_hi   (t_rd_hi),
    .rd_lo   (t_rd_lo),
    .we_hi   (t_we_hi),
    .we_lo   (t_we_lo),
    .wr_addr (t_wr_addr),
    .wr_hi   (t_wr_hi),
    .wr_lo   (t_wr_lo)
  );

  prqs_ram #(
    .DEPTH (LEVEL_COUNT),
    .HI_W  (ID_W),
    .LO_W  (ID_W)
  ) u_queue_mem (
    .clk     (clk),
    .rd_en   (q_rd_en),
    .rd_addr (q_rd_addr),
    .rd_hi   (q_rd_hi),
    .rd_lo   (q_rd_lo),
    .we_hi   (q_we_hi),
    .we_lo   (q_we_lo),
    .wr_addr (q_wr_addr),
    .wr_hi   (q_wr_hi),
    .wr_lo   (q_wr_lo)
  );

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  assign lvl_ok  = !in_level[prqs_pkg::LEVEL_W-1] &&
                   (int'(in_level[prqs_pkg::LEVEL_W-2:0]) < LEVEL_COUNT);
  assign desc_ok = int'(next_free_r) < TASK_COUNT;
  assign rq_ok   = int'(in_ready_id) < int'(next_free_r);

  assign in_lvl_idx = LVL_W'(in_level[prqs_pkg::LEVEL_W-2:0]);
  assign new_id     = next_free_r[ID_W-1:0];
  assign rq_id      = ID_W'(in_ready_id);
  assign prod_full  = prqs_pkg::STACK_W'(next_free_r) * prqs_pkg::STACK_W'(cfg_bytes);
  assign any_ready  = |nonempty_r;

  assign t_lvl     = t_rd_hi[TH_W-1:CR_W];
  assign t_creator = t_rd_hi[CR_W-1:0];

  // most urgent non-empty level
  always_comb begin
    sel_lvl = '0;
    for (int q = LEVEL_COUNT - 1; q >= 0; q--) begin
      if (nonempty_r[q]) begin
        sel_lvl = LVL_W'(q);
      end
    end
  end

  // memory accesses; the sequencer never reads an entry in the cycle it writes it
  always_comb begin
    t_rd_en   = 1'b0;
    t_rd_addr = '0;
    t_we_hi   = 1'b0;
    t_we_lo   = 1'b0;
    t_wr_addr = '0;
    t_wr_hi   = '0;
    t_wr_lo   = '0;
    q_rd_en   = 1'b0;
    q_rd_addr = '0;
    q_we_hi   = 1'b0;
    q_we_lo   = 1'b0;
    q_wr_addr = '0;
    q_wr_hi   = '0;
    q_wr_lo   = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_cmd == prqs_pkg::CMD_CREATE && lvl_ok && desc_ok) begin
            t_we_hi   = 1'b1;
            t_wr_addr = new_id;
            t_wr_hi   = {in_lvl_idx, $unsigned(in_creator_id)};
            q_rd_en   = 1'b1;
            q_rd_addr = in_lvl_idx;
          end else if (in_cmd == prqs_pkg::CMD_SCHEDULE && any_ready) begin
            q_rd_en   = 1'b1;
            q_rd_addr = sel_lvl;
          end else if (in_cmd == prqs_pkg::CMD_REQUEUE && rq_ok) begin
            t_rd_en   = 1'b1;
            t_rd_addr = rq_id;
          end
        end
      end
      S_SC_TASK: begin
        t_rd_en   = 1'b1;
        t_rd_addr = q_rd_hi;
      end
      S_SC_POP: begin
        if (id_r != q_rd_lo) begin
          q_we_hi   = 1'b1;
          q_wr_addr = lvl_r;
          q_wr_hi   = t_rd_lo;
        end
      end
      S_RQ_QUEUE: begin
        q_rd_en   = 1'b1;
        q_rd_addr = t_lvl;
      end
      S_APPEND: begin
        q_we_lo   = 1'b1;
        q_wr_addr = lvl_r;
        q_wr_lo   = id_r;
        if (nonempty_r[lvl_r]) begin
          t_we_lo   = 1'b1;
          t_wr_addr = q_rd_lo;
          t_wr_lo   = id_r;
        end else begin
          q_we_hi = 1'b1;
          q_wr_hi = id_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      next_free_r  <= '0;
      nonempty_r   <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            out_status_r  <= prqs_pkg::ST_OK;
            out_id_r      <= '0;
            out_lvl_r     <= '0;
            out_creator_r <= '0;
            out_stack_r   <= '0;
            priority if (in_cmd == prqs_pkg::CMD_CREATE) begin
              if (!lvl_ok) begin
                out_strobe_r <= 1'b1;
                out_status_r <= prqs_pkg::ST_BAD_LEVEL;
              end else if (!desc_ok) begin
                out_strobe_r <= 1'b1;
                out_status_r <= prqs_pkg::ST_NO_DESC;
              end else begin
                id_r        <= new_id;
                lvl_r       <= in_lvl_idx;
                creator_r   <= $unsigned(in_creator_id);
                prod_r      <= prod_full;
                create_r    <= 1'b1;
                next_free_r <= CNT_W'(next_free_r + 1'b1);
                state_r     <= S_APPEND;
              end
            end else if (in_cmd == prqs_pkg::CMD_SCHEDULE) begin
              if (!any_ready) begin
                out_strobe_r <= 1'b1;
                out_status_r <= prqs_pkg::ST_NONE_READY;
              end else begin
                lvl_r   <= sel_lvl;
                state_r <= S_SC_TASK;
              end
            end else if (in_cmd == prqs_pkg::CMD_REQUEUE) begin
              if (!rq_ok) begin
                out_strobe_r <= 1'b1;
                out_status_r <= prqs_pkg::ST_UNKNOWN;
              end else begin
                id_r     <= rq_id;
                create_r <= 1'b0;
                state_r  <= S_RQ_QUEUE;
              end
            end else begin
              out_strobe_r <= 1'b1;
            end
          end
        end
        S_SC_TASK: begin
          id_r    <= q_rd_hi;
          state_r <= S_SC_POP;
        end
        S_SC_POP: begin
          // last entry of the level: the queue goes empty
          if (id_r == q_rd_lo) begin
            nonempty_r[lvl_r] <= 1'b0;
          end
          out_strobe_r  <= 1'b1;
          out_status_r  <= prqs_pkg::ST_OK;
          out_id_r      <= prqs_pkg::OUT_ID_W'(id_r);
          out_lvl_r     <= prqs_pkg::OUT_LVL_W'(t_lvl);
          out_creator_r <= t_creator;
          out_stack_r   <= '0;
          state_r       <= S_IDLE;
        end
        S_RQ_QUEUE: begin
          lvl_r     <= t_lvl;
          creator_r <= t_creator;
          state_r   <= S_APPEND;
        end
        S_APPEND: begin
          nonempty_r[lvl_r] <= 1'b1;
          out_strobe_r  <= 1'b1;
          out_status_r  <= prqs_pkg::ST_OK;
          out_id_r      <= prqs_pkg::OUT_ID_W'(id_r);
          out_lvl_r     <= prqs_pkg::OUT_LVL_W'(lvl_r);
          out_creator_r <= creator_r;
          out_stack_r   <= create_r ? (cfg_top - prod_r) : '0;
          state_r       <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_strobe         = out_strobe_r;
  assign out_status         = out_status_r;
  assign out_chosen_id      = out_id_r;
  assign out_chosen_level   = out_lvl_r;
  assign out_chosen_creator = $signed(out_creator_r);
  assign out_stack_top      = out_stack_r;

`ifndef SYNTHESIS
  a_alloc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(next_free_r) <= TASK_COUNT)
    else $error("descriptor counter ran past the task count");

  a_queue_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (q_rd_en && (q_we_hi || q_we_lo)) |-> (q_rd_addr != q_wr_addr))
    else $error("queue memory read and written at the same entry");

  a_append_sets_level: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_APPEND) |=> (nonempty_r[$past(lvl_r)] && out_strobe))
    else $error("append did not mark its level ready");

  a_empty_schedule: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_cmd == prqs_pkg::CMD_SCHEDULE && nonempty_r == '0) |=>
      (out_strobe && out_status == prqs_pkg::ST_NONE_READY && !busy))
    else $error("schedule with no ready level not answered at once");
`endif

endmodule

// File: hdl/prqs_ram.sv
// synchronous two-field memory with per-field write enables and registered read
module prqs_ram #(
  parameter int DEPTH = 16,
  parameter int HI_W  = 8,
  parameter int LO_W  = 8
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [HI_W-1:0]          rd_hi,
  output logic [LO_W-1:0]          rd_lo,
  input  logic                     we_hi,
  input  logic                     we_lo,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [HI_W-1:0]          wr_hi,
  input  logic [LO_W-1:0]          wr_lo
);

  logic [HI_W-1:0] mem_hi [DEPTH];
  logic [LO_W-1:0] mem_lo [DEPTH];
  logic [HI_W-1:0] rd_hi_r;
  logic [LO_W-1:0] rd_lo_r;

  always_ff @(posedge clk) begin
    if (we_hi) begin
      mem_hi[wr_addr] <= wr_hi;
    end
    if (we_lo) begin
      mem_lo[wr_addr] <= wr_lo;
    end
    if (rd_en) begin
      rd_hi_r <= mem_hi[rd_addr];
      rd_lo_r <= mem_lo[rd_addr];
    end
  end

  assign rd_hi = rd_hi_r;
  assign rd_lo = rd_lo_r;

endmodule

// File: hdl/prqs_cfg.sv
// apb register file: stack region top and stack bytes per task
module prqs_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [prqs_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [prqs_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [prqs_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready,
  output logic [prqs_pkg::STACK_W-1:0]        stack_top,
  output logic [prqs_pkg::BYTES_W-1:0]        stack_bytes
);

  logic [prqs_pkg::STACK_W-1:0] stack_top_r;
  logic [prqs_pkg::BYTES_W-1:0] stack_bytes_r;
  logic                         wr_en;
  logic                         reg_sel;

  assign reg_sel = paddr[2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stack_top_r   <= prqs_pkg::STACK_TOP_RESET;
      stack_bytes_r <= prqs_pkg::STACK_BYTES_RESET;
    end else if (wr_en) begin
      if (reg_sel == prqs_pkg::REG_STACK_TOP) begin
        stack_top_r <= pwdata;
      end else begin
        stack_bytes_r <= pwdata[prqs_pkg::BYTES_W-1:0];
      end
    end
  end

  always_comb begin
    if (reg_sel == prqs_pkg::REG_STACK_TOP) begin
      prdata = stack_top_r;
    end else begin
      prdata = prqs_pkg::CFG_DATA_W'(stack_bytes_r);
    end
  end

  assign stack_top   = stack_top_r;
  assign stack_bytes = stack_bytes_r;

endmodule
